// ----- src/sscacc_pkg.sv -----
// ----------------------------------------------------------------------------
// sscacc_pkg
// Shared types and constants of the scanline span coverage accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package sscacc_pkg;

  // Coverage storage format.
  localparam int COV_W = 8;

  // Field widths of one input item.
  localparam int ACTION_W = 2;
  localparam int SPAN_W   = 19;
  localparam int COLUMN_W = 10;

  // Width of the active-width register and its value after reset.
  localparam int             AW_REG_W     = 11;
  localparam logic [10:0]    AW_RESET_VAL = 11'd1024;

  // Coverage added to a fully covered column (one fifth of full scale).
  localparam logic [COV_W-1:0] FULL_ADD = 8'd51;
  localparam logic [COV_W-1:0] COV_MAX  = 8'd255;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD_SPAN = 2'd0,
    ACT_READ     = 2'd1,
    ACT_WRITE    = 2'd2
  } action_t;

endpackage

`default_nettype wire

// ----- src/sscacc_row_ram.sv -----
// ----------------------------------------------------------------------------
// sscacc_row_ram
// Row coverage store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sscacc_row_ram
  import sscacc_pkg::*;
#(
  parameter  int DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [COV_W-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [COV_W-1:0] rd_data
);

  logic [COV_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while no read is enabled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- src/scanline_span_coverage_accumulator_unit.sv -----
// ----------------------------------------------------------------------------
// scanline_span_coverage_accumulator_unit
// Add-span item: CALC and PART set up (a span missing the row ends at CALC),
//   then one column per cycle in the row memory's read-modify-write loop, DRAIN.
// Read item: result loaded in READ; write item: at acceptance. One item at a time.
// After reset all MAX_WIDTH columns are cleared at one column per cycle,
//   with no item accepted; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module scanline_span_coverage_accumulator_unit
  import sscacc_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [ACTION_W-1:0]        in_action,
  input  wire logic signed [SPAN_W-1:0]   in_span_start,
  input  wire logic signed [SPAN_W-1:0]   in_span_end,
  input  wire logic [COLUMN_W-1:0]        in_column,
  input  wire logic [COV_W-1:0]           in_write_value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [COV_W-1:0]                out_pixel_value,
  input  wire logic                       cfg_wr_en,
  input  wire logic [AW_REG_W-1:0]        cfg_wr_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic signed [31:0] ONE_FX   = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] MAX_W32  = 32'(MAX_WIDTH);
  localparam logic [AW-1:0]      LAST_COL = AW'(MAX_WIDTH - 1);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_CALC  = 7'b0000100,
    ST_PART  = 7'b0001000,
    ST_RUN   = 7'b0010000,
    ST_DRAIN = 7'b0100000,
    ST_READ  = 7'b1000000
  } state_t;

  function automatic logic signed [31:0] clamp32(input logic signed [31:0] v,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
    logic signed [31:0] r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

  // floor(coverage * 51) for one partly covered column.
  function automatic logic [COV_W-1:0] part_add(input logic [AW-1:0]        col,
                                                input logic signed [31:0] s,
                                                input logic signed [31:0] e);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] cov;
    logic [31:0]        prod;
    lo   = 32'(col) << FRAC_BITS;
    hi   = lo + ONE_FX;
    cov  = clamp32(e, lo, hi) - clamp32(s, lo, hi);
    if (cov < 0) cov = 32'sd0;
    prod = 32'(cov) * 32'(FULL_ADD);
    return prod[FRAC_BITS +: COV_W];
  endfunction

  state_t                    state_r, state_nxt;
  logic [AW_REG_W-1:0]       aw_r;
  logic [AW-1:0]             clr_cnt_r, clr_cnt_nxt;
  logic signed [SPAN_W-1:0]  s_r, e_r;
  logic [AW-1:0]             first_r, last_r, cur_r, cur_nxt;
  logic [AW-1:0]             first_nxt, last_nxt;
  logic [COV_W-1:0]          add_first_r, add_last_r;
  logic                      rd_oob_r;
  logic                      p_valid_r, p_valid_nxt;
  logic [AW-1:0]             p_col_r;
  logic [COV_W-1:0]          p_add_r;
  logic                      p_sat_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [COV_W-1:0]          out_pixel_value_r;
  logic                      out_load;

  logic                      in_accept;
  logic                      col_oob;
  logic                      span_ignore;
  logic signed [31:0]        s32, e32, w32, first32, stop32;

  logic                      mem_we, mem_re;
  logic [AW-1:0]             mem_waddr, mem_raddr;
  logic [COV_W-1:0]          mem_wdata, mem_rdata;
  logic [COV_W:0]            sat_sum;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign col_oob   = 32'(in_column) >= MAX_W32;

  // Span setup arithmetic, evaluated in the CALC state.
  always_comb begin
    s32         = 32'(s_r);
    e32         = 32'(e_r);
    w32         = (32'(aw_r) > MAX_W32) ? MAX_W32 : 32'(aw_r);
    first32     = (s32 < 0) ? 32'sd0 : (s32 >>> FRAC_BITS);
    stop32      = (e32 >>> FRAC_BITS) + 32'sd1;
    if (stop32 > w32) stop32 = w32;
    span_ignore = (w32 == 32'sd0) || (s32 >= (w32 <<< FRAC_BITS)) ||
                  (e32 < 32'sd0) || (e32 < s32);
    first_nxt   = first32[AW-1:0];
    last_nxt    = AW'(stop32 - 32'sd1);
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    cur_nxt     = cur_r;
    p_valid_nxt = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST_COL) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          case (action_t'(in_action))
            ACT_ADD_SPAN: state_nxt = ST_CALC;
            ACT_READ:     state_nxt = ST_READ;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CALC: begin
        state_nxt = span_ignore ? ST_IDLE : ST_PART;
      end
      ST_PART: begin
        cur_nxt   = first_r;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        p_valid_nxt = 1'b1;
        cur_nxt     = cur_r + AW'(1);
        if (cur_r == last_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Memory ports. Within a span each column is touched once, so the read of
  // the next column never meets the write-back of the previous one.
  assign mem_re    = (state_r == ST_RUN) ||
                     (in_accept && (action_t'(in_action) == ACT_READ));
  assign mem_raddr = (state_r == ST_RUN) ? cur_r : AW'(in_column);
  assign sat_sum   = {1'b0, mem_rdata} + {1'b0, p_add_r};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(in_column);
    mem_wdata = in_write_value;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (p_valid_r) begin
      mem_we    = 1'b1;
      mem_waddr = p_col_r;
      if (p_sat_r) begin
        mem_wdata = sat_sum[COV_W] ? COV_MAX : sat_sum[COV_W-1:0];
      end else begin
        mem_wdata = mem_rdata + FULL_ADD;
      end
    end else if (in_accept && (action_t'(in_action) == ACT_WRITE) && !col_oob) begin
      mem_we = 1'b1;
    end
  end

  sscacc_row_ram #(
    .DEPTH (MAX_WIDTH)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      aw_r        <= AW_RESET_VAL;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        aw_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (in_accept) begin
      s_r      <= in_span_start;
      e_r      <= in_span_end;
      rd_oob_r <= col_oob;
    end
    if (state_r == ST_CALC) begin
      first_r <= first_nxt;
      last_r  <= last_nxt;
    end
    if (state_r == ST_PART) begin
      add_first_r <= part_add(first_r, 32'(s_r), 32'(e_r));
      add_last_r  <= part_add(last_r, 32'(s_r), 32'(e_r));
    end
    if (state_r == ST_RUN) begin
      p_col_r <= cur_r;
      if (cur_r == first_r) begin
        p_add_r <= add_first_r;
        p_sat_r <= 1'b1;
      end else if (cur_r == last_r) begin
        p_add_r <= add_last_r;
        p_sat_r <= 1'b1;
      end else begin
        p_add_r <= FULL_ADD;
        p_sat_r <= 1'b0;
      end
    end
    if (out_load) begin
      out_pixel_value_r <= rd_oob_r ? '0 : mem_rdata;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_pixel_value_r;

endmodule

`default_nettype wire

// ----- test/tb_scanline_span_coverage_accumulator_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scanline_span_coverage_accumulator_unit
// Self-checking bench for the scanline span coverage accumulator. A driver
// feeds items from a backlog queue and a local row model predicts every read.
// A monitor compares each returned pixel value with the oldest prediction.
// The run steps through several active widths and sender/receiver idle mixes.
// ----------------------------------------------------------------------------

module tb_scanline_span_coverage_accumulator_unit;
  import sscacc_pkg::*;

  localparam int ROW_COLS = 1024;
  localparam int FX_ONE = 256;
  localparam longint SPAN_MAX = 262143;
  localparam int DRAIN_CYCLES = 1100;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS = 200;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [ACTION_W-1:0]      action;
    logic signed [SPAN_W-1:0] span_start;
    logic signed [SPAN_W-1:0] span_end;
    logic [COLUMN_W-1:0]      column;
    logic [COV_W-1:0]         write_value;
  } coverage_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ACTION_W-1:0] in_action = '0;
  logic signed [SPAN_W-1:0] in_span_start = '0;
  logic signed [SPAN_W-1:0] in_span_end = '0;
  logic [COLUMN_W-1:0] in_column = '0;
  logic [COV_W-1:0] in_write_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [COV_W-1:0] out_pixel_value;
  logic cfg_wr_en = 1'b0;
  logic [AW_REG_W-1:0] cfg_wr_data = '0;

  coverage_item_t item_backlog[$];
  logic [COV_W-1:0] expected_pixels[$];
  logic [COV_W-1:0] row_cov [ROW_COLS];
  logic [AW_REG_W-1:0] model_width = AW_RESET_VAL;
  coverage_item_t cur_item;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int stall_cycles = 0;
  int launch_count = 0;
  int hot_col = 0;
  bit drain_hold = 1'b0;

  scanline_span_coverage_accumulator_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_span_start  (in_span_start),
    .in_span_end    (in_span_end),
    .in_column      (in_column),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_value(out_pixel_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #6 clk = ~clk;

  function automatic void queue_item(coverage_item_t it);
    item_backlog = {item_backlog, it};
  endfunction

  function automatic longint clamp_fx(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Edge columns get the covered fraction of 51, saturating at full scale.
  function automatic void add_edge_coverage(longint col, longint s, longint e);
    longint lo;
    longint cov;
    int sum;
    lo = col * FX_ONE;
    cov = clamp_fx(e, lo, lo + FX_ONE) - clamp_fx(s, lo, lo + FX_ONE);
    if (col < 0 || col >= ROW_COLS) return;
    if (cov < 0) cov = 0;
    sum = int'(row_cov[col]) + int'((cov * 51) >>> 8);
    row_cov[col] = (sum > 255) ? COV_MAX : COV_W'(sum);
  endfunction

  function automatic void accumulate_span(longint s, longint e);
    longint w;
    longint first;
    longint stop;
    w = (model_width > ROW_COLS) ? ROW_COLS : model_width;
    if (w <= 0) return;
    if (s >= w * FX_ONE || e < 0 || e < s) return;
    first = (s < 0) ? 0 : (s >>> 8);
    stop = (e >>> 8) + 1;
    if (stop > w) stop = w;
    if (stop - first < 1) return;
    add_edge_coverage(first, s, e);
    if (stop - first > 1) begin
      // Interior columns wrap rather than saturate.
      for (longint c = first + 1; c < stop - 1; c++) row_cov[c] = row_cov[c] + FULL_ADD;
      add_edge_coverage(stop - 1, s, e);
    end
  endfunction

  function automatic void apply_to_row(coverage_item_t it);
    if (it.action == ACT_ADD_SPAN) begin
      accumulate_span(longint'(it.span_start), longint'(it.span_end));
    end else if (it.action == ACT_READ) begin
      expected_pixels = {expected_pixels, row_cov[it.column]};
    end else if (it.action == ACT_WRITE) begin
      row_cov[it.column] = it.write_value;
    end
  endfunction

  function automatic coverage_item_t make_item(logic [ACTION_W-1:0] act, longint s, longint e,
                                               int col, int val);
    coverage_item_t it;
    it.action = act;
    it.span_start = SPAN_W'(s);
    it.span_end = SPAN_W'(e);
    it.column = COLUMN_W'(col);
    it.write_value = COV_W'(val);
    return it;
  endfunction

  function automatic coverage_item_t random_coverage_item();
    coverage_item_t it;
    int pick;
    int w_eff;
    int start_col;
    int len;
    int frac_s;
    longint s;
    longint e;
    pick = $urandom_range(99);
    w_eff = (model_width == 0) ? 1 : ((model_width > ROW_COLS) ? ROW_COLS : model_width);
    it = make_item(ACT_READ, 0, 0, 0, 0);
    it.span_start = SPAN_W'($urandom);
    it.span_end = SPAN_W'($urandom);
    it.column = COLUMN_W'($urandom);
    it.write_value = COV_W'($urandom);
    if (pick < 45) begin
      start_col = int'($urandom_range(w_eff + 3)) - 2;
      if ($urandom_range(99) < 20) len = 0;
      else if ($urandom_range(99) < 4) len = $urandom_range(1100);
      else len = $urandom_range(40);
      frac_s = $urandom_range(255);
      s = longint'(start_col) * FX_ONE + frac_s;
      if (len == 0) e = s + $urandom_range(255 - frac_s);
      else e = longint'(start_col + len) * FX_ONE + $urandom_range(255);
      if (s > SPAN_MAX) s = SPAN_MAX;
      if (e > SPAN_MAX) e = SPAN_MAX;
      it.action = ACT_ADD_SPAN;
      it.span_start = SPAN_W'(s);
      it.span_end = SPAN_W'(e);
      hot_col = (start_col < 0) ? 0 : ((start_col > ROW_COLS - 1) ? ROW_COLS - 1 : start_col);
    end else if (pick < 50) begin
      // Raw span fields: often reversed or outside the row.
      it.action = ACT_ADD_SPAN;
    end else if (pick < 80) begin
      it.action = ACT_READ;
      if ($urandom_range(1)) it.column = COLUMN_W'(hot_col + $urandom_range(12));
    end else if (pick < 95) begin
      it.action = ACT_WRITE;
      if ($urandom_range(1)) it.column = COLUMN_W'(hot_col + $urandom_range(12));
      if ($urandom_range(99) < 30) it.write_value = COV_W'($urandom_range(255, 200));
    end else begin
      it.action = ACT_UNUSED;
    end
    return it;
  endfunction

  // Driver: predicts each accepted item, then loads the next one or idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_to_row(cur_item);
      if (!in_valid || in_ready) begin
        if (drain_hold && expected_pixels.size() != 0) begin
          in_valid <= 1'b0;
        end else if (item_backlog.size() == 0 || $urandom_range(99) < send_idle_pct) begin
          in_valid <= 1'b0;
        end else begin
          cur_item = item_backlog.pop_front();
          launch_count++;
          // Now and then hold the next item back until every read has returned.
          drain_hold = (launch_count % 97 == 0) || ($urandom_range(99) < 2);
          in_action <= cur_item.action;
          in_span_start <= cur_item.span_start;
          in_span_end <= cur_item.span_end;
          in_column <= cur_item.column;
          in_write_value <= cur_item.write_value;
          in_valid <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    logic [COV_W-1:0] want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel value %0d", $time, out_pixel_value);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_value !== want) begin
            $display("%0t: pixel_value mismatch: expected %0d, got %0d",
                     $time, want, out_pixel_value);
            mismatch_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int widths[9];
    widths = '{1024, 1, 0, 2047, 300, 17, 2, 1023, 640};
    foreach (row_cov[i]) row_cov[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < 9; p++) begin
      @(negedge clk);
      send_idle_pct = (p < 3) ? 24 : ((p < 6) ? 71 : 0);
      recv_stall_pct = (p < 3) ? 71 : ((p < 6) ? 24 : 0);
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= AW_REG_W'(widths[p]);
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      model_width = AW_REG_W'(widths[p]);
      @(negedge clk);
      if (p == 0) begin
        queue_item(make_item(ACT_ADD_SPAN, 0, SPAN_MAX, 0, 0));
        queue_item(make_item(ACT_READ, 0, 0, 0, 0));
        queue_item(make_item(ACT_READ, 0, 0, 1023, 0));
        queue_item(make_item(ACT_READ, 0, 0, 500, 0));
        queue_item(make_item(ACT_WRITE, 0, 0, 7, 255));
        queue_item(make_item(ACT_ADD_SPAN, 7 * 256, 7 * 256 + 255, 0, 0));
        queue_item(make_item(ACT_READ, 0, 0, 7, 0));
        queue_item(make_item(ACT_WRITE, 0, 0, 9, 250));
        queue_item(make_item(ACT_ADD_SPAN, 8 * 256 + 128, 10 * 256 + 5, 0, 0));
        queue_item(make_item(ACT_READ, 0, 0, 8, 0));
        queue_item(make_item(ACT_READ, 0, 0, 9, 0));
        queue_item(make_item(ACT_READ, 0, 0, 10, 0));
        queue_item(make_item(ACT_ADD_SPAN, -262144, 300, 0, 0));
        queue_item(make_item(ACT_READ, 0, 0, 0, 0));
        queue_item(make_item(ACT_READ, 0, 0, 1, 0));
        queue_item(make_item(ACT_ADD_SPAN, 5 * 256 + 10, 5 * 256 + 200, 0, 0));
        queue_item(make_item(ACT_READ, 0, 0, 5, 0));
        queue_item(make_item(ACT_ADD_SPAN, 1000, 999, 0, 0));
        queue_item(make_item(ACT_ADD_SPAN, SPAN_MAX, SPAN_MAX, 0, 0));
        queue_item(make_item(ACT_ADD_SPAN, -500, -1, 0, 0));
        queue_item(make_item(ACT_UNUSED, -1, -1, 1023, 255));
        queue_item(make_item(ACT_WRITE, 0, 0, 1023, 8'hAA));
        queue_item(make_item(ACT_READ, 0, 0, 1023, 0));
        queue_item(make_item(ACT_READ, 0, 0, 4, 0));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) queue_item(random_coverage_item());

      // Let the row settle before the width changes: spans return nothing.
      do @(negedge clk);
      while (item_backlog.size() != 0 || in_valid || expected_pixels.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clk);
    end

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
